@@ rtl/ptba_pkg.sv @@
package ptba_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int DATA_START_DEF  = 65536;
    localparam int FLASH_BYTES_DEF = 67108864;

    localparam int SPACE_W = 27;
    localparam int KEY_W   = 64;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_ADD     = 3'd1,
        OP_FIND    = 3'd2,
        OP_UPDATE  = 3'd3,
        OP_DELETE  = 3'd4,
        OP_COLLECT = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_NO_SPACE  = 2'd1,
        RC_FULL      = 2'd2,
        RC_NOT_FOUND = 2'd3
    } rc_t;

    localparam logic [2:0] ST_EMPTY    = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_DEPLOYED = 3'd2;

    // One table entry as held in the slot memory (status lives apart).
    typedef struct packed {
        logic [63:0] key;
        logic [23:0] attrs;
        logic [31:0] address;
        logic [31:0] size;
        logic [31:0] crc;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_COLL,
        S_FIX,
        S_READ,
        S_RDATA,
        S_OUT
    } state_t;

    // Keep bytes up to the first zero byte, limited to KEY_BYTES.
    function automatic logic [63:0] norm_key(input logic [63:0] k, input int kb);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= kb || k[8*i +: 8] == 8'h00)
                stop = 1'b1;
            if (!stop)
                r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

endpackage

@@ rtl/ptba_mem.sv @@
module ptba_mem #(
    parameter int SLOTS = ptba_pkg::SLOTS_DEF,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  ptba_pkg::entry_t       wdata,
    input  logic [AW-1:0]          raddr,
    output ptba_pkg::entry_t       rdata
);

    ptba_pkg::entry_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ptba_kmem.sv @@
module ptba_kmem #(
    parameter int SLOTS = ptba_pkg::SLOTS_DEF,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wkey,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rkey
);

    logic [63:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wkey;
        rkey <= mem[raddr];
    end

endmodule

@@ rtl/package_table_with_bump_allocator.sv @@
// Channel | Dir | tdata fields (low bit up)
// s_axis  | in  | op, ecu_key, byte_count, target_kind, bus_kind, install_condition,
//         |     | package_address, image_crc, status_value (190 bits, padded to 192)
// m_axis  | out | result_code, alloc_address, found_address, found_size, found_kind,
//         |     | found_bus, found_condition, found_status, found_crc, entries_used,
//         |     | space_left, packages_seen (216 bits)
// After a command is accepted, add and an undefined op go straight to the output state;
// collect scans one status slot per cycle, and allocate runs at most one collect pass.
// Find, update and delete compare one key per cycle from the key memory, then read
// the entry. rst_n clears status bits, counters and the free-space pointers; slot
// memories are not cleared. A held result blocks the next command until taken, and
// input is ready again in the cycle after that transfer.
module package_table_with_bump_allocator #(
    parameter int SLOTS       = ptba_pkg::SLOTS_DEF,
    parameter int KEY_BYTES   = ptba_pkg::KEY_BYTES_DEF,
    parameter int DATA_START  = ptba_pkg::DATA_START_DEF,
    parameter int FLASH_BYTES = ptba_pkg::FLASH_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op, ecu_key, byte_count, target_kind, bus_kind, install_condition,
    // package_address, image_crc, status_value
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_code, alloc_address, found_address, found_size, found_kind, found_bus,
    // found_condition, found_status, found_crc, entries_used, space_left, packages_seen
    output logic [215:0] m_axis_tdata
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [26:0] START0 = 27'(DATA_START);
    localparam logic [26:0] SIZE0  =
        (DATA_START <= FLASH_BYTES) ? 27'(FLASH_BYTES - DATA_START) : 27'd0;
    localparam logic [CW:0] SLOTS_C = (CW+1)'(SLOTS);
    localparam logic [AW:0] LAST_C  = (AW+1)'(SLOTS - 1);

    ptba_pkg::state_t state_reg, state_next;

    logic [2:0]  op_reg;
    logic [63:0] key_reg;
    logic [31:0] cnt_reg;
    logic [23:0] attr_reg;
    logic [31:0] addr_reg, crc_reg;
    logic [2:0]  stv_reg;

    logic [2:0]  status_reg [SLOTS];
    logic [CW:0] used_reg;
    logic [26:0] start_reg, size_reg;
    logic [31:0] added_reg, bytes_reg;

    logic [AW:0] idx_reg;
    logic        pend_reg;          // a scan read is in flight
    logic [AW-1:0] pidx_reg;
    logic        hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic        removed_reg;
    logic        pass2_reg;         // allocate: its collect pass is done

    logic [1:0]  rc_reg;
    logic [26:0] aout_reg;
    ptba_pkg::entry_t fnd_reg;
    logic [2:0]  fst_reg;
    logic        ovalid_reg;

    ptba_pkg::entry_t mrd, mwd;
    logic [63:0] krd;
    logic        mwe;
    logic [AW-1:0] mra, mwa;

    ptba_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
        .clk(clk), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd));
    ptba_kmem #(.SLOTS(SLOTS), .AW(AW)) u_kmem (
        .clk(clk), .we(mwe), .waddr(mwa), .wkey(mwd.key), .raddr(mra), .rkey(krd));

    logic accept;
    assign s_axis_tready = (state_reg == ptba_pkg::S_IDLE) && !ovalid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Collect is needed for allocate when size is zero/too big or the table is full.
    logic need_coll;
    assign need_coll = (cnt_reg == 32'd0) || (cnt_reg > {5'd0, size_reg})
                       || (used_reg >= SLOTS_C);
    logic scan_done;
    assign scan_done = (idx_reg == LAST_C);

    logic first_empty_found;
    logic [AW-1:0] first_empty;
    always_comb
    begin
        first_empty_found = 1'b0;
        first_empty = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (status_reg[i] == ptba_pkg::ST_EMPTY) begin
                first_empty_found = 1'b1;
                first_empty = AW'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptba_pkg::S_IDLE:
                if (accept) begin
                    priority case (s_axis_tdata[2:0])
                        ptba_pkg::OP_ALLOC:   state_next = ptba_pkg::S_FIX;
                        ptba_pkg::OP_ADD:     state_next = ptba_pkg::S_OUT;
                        ptba_pkg::OP_FIND, ptba_pkg::OP_UPDATE,
                        ptba_pkg::OP_DELETE:  state_next = ptba_pkg::S_SCAN;
                        ptba_pkg::OP_COLLECT: state_next = ptba_pkg::S_COLL;
                        default:              state_next = ptba_pkg::S_OUT;
                    endcase
                end
            ptba_pkg::S_SCAN:
                if (pend_reg && (krd == key_reg)
                    && status_reg[pidx_reg] != ptba_pkg::ST_EMPTY)
                    state_next = ptba_pkg::S_READ;
                else if (!pend_reg && idx_reg > LAST_C)
                    state_next = ptba_pkg::S_READ;
            ptba_pkg::S_COLL:
                if (scan_done)
                    state_next = (op_reg == ptba_pkg::OP_ALLOC) ?
                                 ptba_pkg::S_FIX : ptba_pkg::S_OUT;
            ptba_pkg::S_FIX:
                if (need_coll && !pass2_reg) state_next = ptba_pkg::S_COLL;
                else state_next = ptba_pkg::S_OUT;
            ptba_pkg::S_READ:  state_next = ptba_pkg::S_RDATA;
            ptba_pkg::S_RDATA: state_next = ptba_pkg::S_OUT;
            ptba_pkg::S_OUT:   state_next = ptba_pkg::S_IDLE;
            default:           state_next = ptba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        mwe = 1'b0;
        mwa = first_empty;
        mwd.key = key_reg;
        mwd.attrs = attr_reg;
        mwd.address = addr_reg;
        mwd.size = cnt_reg;
        mwd.crc = crc_reg;
        mra = idx_reg[AW-1:0];
        if (state_reg == ptba_pkg::S_READ)
            mra = hit_idx_reg;
        if (state_reg == ptba_pkg::S_OUT && op_reg == ptba_pkg::OP_ADD
            && used_reg < SLOTS_C && first_empty_found)
            mwe = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg   <= s_axis_tdata[2:0];
            key_reg  <= ptba_pkg::norm_key(s_axis_tdata[66:3], KEY_BYTES);
            cnt_reg  <= s_axis_tdata[98:67];
            attr_reg <= s_axis_tdata[122:99];
            addr_reg <= s_axis_tdata[154:123];
            crc_reg  <= s_axis_tdata[186:155];
            stv_reg  <= s_axis_tdata[189:187];
        end
        if (state_reg == ptba_pkg::S_RDATA)
            fnd_reg <= mrd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ptba_pkg::S_IDLE;
            for (int i = 0; i < SLOTS; i++) status_reg[i] <= ptba_pkg::ST_EMPTY;
            used_reg    <= '0;
            start_reg   <= START0;
            size_reg    <= SIZE0;
            added_reg   <= '0;
            bytes_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            pidx_reg    <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
            removed_reg <= 1'b0;
            pass2_reg   <= 1'b0;
            rc_reg      <= ptba_pkg::RC_OK;
            aout_reg    <= '0;
            fst_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ptba_pkg::S_IDLE:
                begin
                    idx_reg     <= '0;
                    pend_reg    <= 1'b0;
                    hit_reg     <= 1'b0;
                    removed_reg <= 1'b0;
                    pass2_reg   <= 1'b0;
                    // The result fields stay put while a result waits.
                    if (accept)
                    begin
                        rc_reg   <= ptba_pkg::RC_OK;
                        aout_reg <= '0;
                        fst_reg  <= '0;
                    end
                end
                ptba_pkg::S_SCAN:
                begin
                    if (pend_reg && (krd == key_reg)
                        && status_reg[pidx_reg] != ptba_pkg::ST_EMPTY) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= pidx_reg;
                    end else begin
                        pend_reg <= (idx_reg <= LAST_C);
                        pidx_reg <= idx_reg[AW-1:0];
                        if (idx_reg <= LAST_C)
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                ptba_pkg::S_COLL:
                begin
                    if (status_reg[idx_reg[AW-1:0]] == ptba_pkg::ST_DEPLOYED) begin
                        status_reg[idx_reg[AW-1:0]] <= ptba_pkg::ST_EMPTY;
                        if (used_reg != '0) used_reg <= used_reg - 1'b1;
                        removed_reg <= 1'b1;
                    end
                    if (scan_done) begin
                        idx_reg <= '0;
                        if (op_reg == ptba_pkg::OP_ALLOC) pass2_reg <= 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ptba_pkg::S_FIX:
                begin
                    // The space reset after an allocate's collect pass lands here.
                    if (removed_reg && used_reg == '0) begin
                        start_reg <= START0;
                        size_reg  <= SIZE0;
                        removed_reg <= 1'b0;
                    end
                end
                ptba_pkg::S_READ:
                begin
                    if (!hit_reg)
                        rc_reg <= ptba_pkg::RC_NOT_FOUND;
                end
                ptba_pkg::S_RDATA:
                begin
                    if (hit_reg) begin
                        unique case (op_reg)
                            ptba_pkg::OP_FIND:   fst_reg <= status_reg[hit_idx_reg];
                            ptba_pkg::OP_UPDATE: status_reg[hit_idx_reg] <= stv_reg;
                            ptba_pkg::OP_DELETE:
                            begin
                                status_reg[hit_idx_reg] <= ptba_pkg::ST_EMPTY;
                                if (used_reg != '0) used_reg <= used_reg - 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ptba_pkg::S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    if (op_reg == ptba_pkg::OP_COLLECT && removed_reg && used_reg == '0)
                    begin
                        start_reg <= START0;
                        size_reg  <= SIZE0;
                    end
                    if (op_reg == ptba_pkg::OP_ALLOC) begin
                        if (cnt_reg > {5'd0, size_reg})
                            rc_reg <= ptba_pkg::RC_NO_SPACE;
                        else if (used_reg >= SLOTS_C)
                            rc_reg <= ptba_pkg::RC_FULL;
                        else begin
                            aout_reg  <= start_reg;
                            start_reg <= start_reg + cnt_reg[26:0];
                            size_reg  <= size_reg - cnt_reg[26:0];
                        end
                    end
                    if (op_reg == ptba_pkg::OP_ADD) begin
                        if (used_reg >= SLOTS_C || !first_empty_found)
                            rc_reg <= ptba_pkg::RC_FULL;
                        else begin
                            status_reg[first_empty] <= ptba_pkg::ST_COMPLETE;
                            used_reg  <= used_reg + 1'b1;
                            added_reg <= added_reg + 32'd1;
                            bytes_reg <= bytes_reg + cnt_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Find result fields read as zero unless this was a successful find.
    logic show;
    assign show = (op_reg == ptba_pkg::OP_FIND) && (rc_reg == ptba_pkg::RC_OK);

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {
        added_reg,
        size_reg,
        5'(used_reg),
        show ? fnd_reg.crc : 32'd0,
        show ? fst_reg : 3'd0,
        show ? fnd_reg.attrs : 24'd0,
        show ? fnd_reg.size : 32'd0,
        show ? fnd_reg.address : 32'd0,
        aout_reg,
        rc_reg
    };

endmodule

@@ rtl/ptba_check.sv @@
module ptba_check (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [215:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("command taken while a result waits");

    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("command finished too early");

    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[156:152] <= 5'd16)
        else $error("entry count out of range");

endmodule

bind package_table_with_bump_allocator ptba_check u_check (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));
